// ----- sv/tpc_pkg.sv -----
// Shared types, constants and helpers for the temperature/pressure compensation unit.
// No dependencies.
package tpc_pkg;

  localparam int unsigned NumRegs = 6;
  localparam int unsigned RawW    = 20;
  localparam int unsigned TempW   = 16;
  localparam int unsigned PressW  = 18;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned DivStages = 32;

  localparam logic [RegIdxW-1:0] REG_T1_T2 = 3'd0;
  localparam logic [RegIdxW-1:0] REG_T3_P1 = 3'd1;
  localparam logic [RegIdxW-1:0] REG_P2_P3 = 3'd2;
  localparam logic [RegIdxW-1:0] REG_P4_P5 = 3'd3;
  localparam logic [RegIdxW-1:0] REG_P6_P7 = 3'd4;
  localparam logic [RegIdxW-1:0] REG_P8_P9 = 3'd5;

  localparam logic [31:0] PressOffset = 32'd64000;
  localparam logic [31:0] PressBase   = 32'd1048576;
  localparam logic [31:0] PressScale  = 32'd3125;
  localparam logic [31:0] SignBit     = 32'h8000_0000;
  localparam logic [31:0] DivOne      = 32'd32768;
  localparam logic [31:0] TempRound   = 32'd128;
  localparam logic [PressW-1:0] PressMax = '1;

  typedef struct packed {
    logic [31:0] regs0;
    logic [31:0] regs1;
    logic [31:0] regs2;
    logic [31:0] regs3;
    logic [31:0] regs4;
    logic [31:0] regs5;
  } cal_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return p[31:0];
  endfunction

endpackage

// ----- sv/tpc_cfg.sv -----
// Calibration register file for the compensation unit.
// Depends on tpc_pkg.
module tpc_cfg import tpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [RegIdxW-1:0] cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  output cal_t               cal_o
);
  cal_t cal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_T1_T2: cal_q.regs0 <= cfg_wdata_i;
        REG_T3_P1: cal_q.regs1 <= cfg_wdata_i;
        REG_P2_P3: cal_q.regs2 <= cfg_wdata_i;
        REG_P4_P5: cal_q.regs3 <= cfg_wdata_i;
        REG_P6_P7: cal_q.regs4 <= cfg_wdata_i;
        REG_P8_P9: cal_q.regs5 <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cal_o = cal_q;
endmodule

// ----- sv/tpc_div.sv -----
// Pipelined restoring 32/32 unsigned divider, one quotient bit per stage.
// Depends on tpc_pkg; carries a side payload along with each word.
module tpc_div import tpc_pkg::*; #(
  parameter int unsigned SideW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [31:0]      num_i,
  input  logic [31:0]      den_i,
  input  logic [SideW-1:0] side_i,
  output logic             vld_o,
  output logic [31:0]      quo_o,
  output logic [SideW-1:0] side_o
);
  logic                    vld_q  [DivStages];
  logic [31:0]             num_q  [DivStages];
  logic [31:0]             den_q  [DivStages];
  logic [31:0]             rem_q  [DivStages];
  logic [SideW-1:0]        side_q [DivStages];

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    logic             vld_c;
    logic [31:0]      num_c, den_c, rem_c;
    logic [SideW-1:0] side_c;
    logic [32:0]      trial;
    logic [33:0]      diff;

    if (s == 0) begin : g_head
      assign vld_c  = vld_i;
      assign num_c  = num_i;
      assign den_c  = den_i;
      assign rem_c  = '0;
      assign side_c = side_i;
    end else begin : g_body
      assign vld_c  = vld_q[s-1];
      assign num_c  = num_q[s-1];
      assign den_c  = den_q[s-1];
      assign rem_c  = rem_q[s-1];
      assign side_c = side_q[s-1];
    end

    assign trial = {rem_c, num_c[31]};
    assign diff  = {1'b0, trial} - {2'b0, den_c};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s]  <= den_c;
        side_q[s] <= side_c;
        if (!diff[33]) begin
          rem_q[s] <= diff[31:0];
          num_q[s] <= {num_c[30:0], 1'b1};
        end else begin
          rem_q[s] <= trial[31:0];
          num_q[s] <= {num_c[30:0], 1'b0};
        end
      end
    end
  end

  assign vld_o  = vld_q[DivStages-1];
  assign quo_o  = num_q[DivStages-1];
  assign side_o = side_q[DivStages-1];
endmodule

// ----- sv/temp_press_compensation_unit.sv -----
// Top level of the temperature/pressure compensation unit.
// Stages s1-s10, divider, s11-s13, output register; one word per cycle unless stalled.
// The pipeline advances when the output register is empty or being taken.
// Reset clears all valid bits and the calibration registers to zero.
// Depends on tpc_pkg, tpc_cfg and tpc_div.
module temp_press_compensation_unit import tpc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [RegIdxW-1:0]       cfg_idx_i,
  input  logic [31:0]              cfg_wdata_i,
  input  logic                     valid_i,
  output logic                     stall_o,
  input  logic [RawW-1:0]          raw_temperature_i,
  input  logic [RawW-1:0]          raw_pressure_i,
  output logic                     valid_o,
  input  logic                     stall_i,
  output logic signed [TempW-1:0]  temperature_centi_o,
  output logic [PressW-1:0]        pressure_pa_o
);
  cal_t cal;
  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;

  tpc_cfg u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .cal_o(cal)
  );

  assign t1 = {16'b0, cal.regs0[15:0]};
  assign t2 = sx16(cal.regs0[31:16]);
  assign t3 = sx16(cal.regs1[15:0]);
  assign p1 = {16'b0, cal.regs1[31:16]};
  assign p2 = sx16(cal.regs2[15:0]);
  assign p3 = sx16(cal.regs2[31:16]);
  assign p4 = sx16(cal.regs3[15:0]);
  assign p5 = sx16(cal.regs3[31:16]);
  assign p6 = sx16(cal.regs4[15:0]);
  assign p7 = sx16(cal.regs4[31:16]);
  assign p8 = sx16(cal.regs5[15:0]);
  assign p9 = sx16(cal.regs5[31:16]);

  logic en;
  logic out_vld_q;
  assign en      = !out_vld_q || !stall_i;
  assign stall_o = !en;

  // s1: differences
  logic        v1_q;
  logic [31:0] s1_x_q, s1_d_q;
  logic [19:0] s1_p_q;
  // s2: first products
  logic        v2_q;
  logic [31:0] s2_a_q, s2_dd_q;
  logic [19:0] s2_p_q;
  // s3: t3 product
  logic        v3_q;
  logic [31:0] s3_a_q, s3_b_q;
  logic [19:0] s3_p_q;
  // s4: fine
  logic        v4_q;
  logic [31:0] s4_f_q;
  logic [19:0] s4_p_q;
  // s5: temperature product, a and q
  logic        v5_q;
  logic [31:0] s5_tc_q, s5_a_q, s5_q_q;
  logic [19:0] s5_p_q;
  // s6: qq, a*p5, p2*a
  logic        v6_q;
  logic [15:0] s6_t_q;
  logic [31:0] s6_qq_q, s6_ap5_q, s6_p2a_q;
  logic [19:0] s6_p_q;
  // s7: p6 and p3 products
  logic        v7_q;
  logic [15:0] s7_t_q;
  logic [31:0] s7_b6_q, s7_ap5_q, s7_p3_q, s7_p2a_q;
  logic [19:0] s7_p_q;
  // s8: b and a sums
  logic        v8_q;
  logic [15:0] s8_t_q;
  logic [31:0] s8_b_q, s8_a_q;
  logic [19:0] s8_p_q;
  // s9: divisor product and numerator base
  logic        v9_q;
  logic [15:0] s9_t_q;
  logic [31:0] s9_den_q, s9_n_q;
  // s10: scale numerator
  logic        v10_q;
  logic [15:0] s10_t_q;
  logic [31:0] s10_den_q, s10_n_q;

  logic [31:0] tc_d;
  logic [15:0] ts_d;
  logic [31:0] a_d, b_d, a8_d, n9_d;

  always_comb begin
    tc_d = asr(s5_tc_q, 8);
    if ($signed(tc_d) < -32768)     ts_d = 16'h8000;
    else if ($signed(tc_d) > 32767) ts_d = 16'h7fff;
    else                            ts_d = tc_d[15:0];
    b_d  = asr(s7_b6_q + (s7_ap5_q << 1), 2) + (p4 << 16);
    a8_d = asr(asr(s7_p3_q, 3) + asr(s7_p2a_q, 1), 18);
    a_d  = DivOne + a8_d;
    n9_d = (PressBase - {12'b0, s8_p_q}) - asr(s8_b_q, 12);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q} <= '0;
    end else if (en) begin
      v1_q  <= valid_i;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
      v5_q  <= v4_q;
      v6_q  <= v5_q;
      v7_q  <= v6_q;
      v8_q  <= v7_q;
      v9_q  <= v8_q;
      v10_q <= v9_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_x_q   <= {15'b0, raw_temperature_i[19:3]} - (t1 << 1);
      s1_d_q   <= {16'b0, raw_temperature_i[19:4]} - t1;
      s1_p_q   <= raw_pressure_i;
      s2_a_q   <= asr(mul32(s1_x_q, t2), 11);
      s2_dd_q  <= asr(mul32(s1_d_q, s1_d_q), 12);
      s2_p_q   <= s1_p_q;
      s3_a_q   <= s2_a_q;
      s3_b_q   <= asr(mul32(s2_dd_q, t3), 14);
      s3_p_q   <= s2_p_q;
      s4_f_q   <= s3_a_q + s3_b_q;
      s4_p_q   <= s3_p_q;
      s5_tc_q  <= mul32(s4_f_q, 32'd5) + TempRound;
      s5_a_q   <= asr(s4_f_q, 1) - PressOffset;
      s5_q_q   <= asr(asr(s4_f_q, 1) - PressOffset, 2);
      s5_p_q   <= s4_p_q;
      s6_t_q   <= ts_d;
      s6_qq_q  <= mul32(s5_q_q, s5_q_q);
      s6_ap5_q <= mul32(s5_a_q, p5);
      s6_p2a_q <= mul32(p2, s5_a_q);
      s6_p_q   <= s5_p_q;
      s7_t_q   <= s6_t_q;
      s7_b6_q  <= mul32(asr(s6_qq_q, 11), p6);
      s7_p3_q  <= mul32(p3, asr(s6_qq_q, 13));
      s7_ap5_q <= s6_ap5_q;
      s7_p2a_q <= s6_p2a_q;
      s7_p_q   <= s6_p_q;
      s8_t_q   <= s7_t_q;
      s8_b_q   <= b_d;
      s8_a_q   <= a_d;
      s8_p_q   <= s7_p_q;
      s9_t_q   <= s8_t_q;
      s9_den_q <= asr(mul32(s8_a_q, p1), 15);
      s9_n_q   <= n9_d;
      s10_t_q  <= s9_t_q;
      s10_den_q <= s9_den_q;
      s10_n_q  <= mul32(s9_n_q, PressScale);
    end
  end

  // divider: side payload = temperature, zero flag, high-bit flag
  localparam int unsigned SideW = TempW + 2;
  logic [31:0]      div_num;
  logic             div_vld;
  logic [31:0]      div_quo;
  logic [SideW-1:0] div_side;
  assign div_num = (s10_n_q < SignBit) ? (s10_n_q << 1) : s10_n_q;

  tpc_div #(.SideW(SideW)) u_div (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v10_q),
    .num_i(div_num), .den_i(s10_den_q),
    .side_i({s10_t_q, s10_den_q == '0, s10_n_q >= SignBit}),
    .vld_o(div_vld), .quo_o(div_quo), .side_o(div_side)
  );

  // post stages
  logic        v11_q, v12_q, v13_q;
  logic [15:0] s11_t_q, s12_t_q, s13_t_q;
  logic        s11_z_q, s12_z_q, s13_z_q;
  logic [31:0] s11_p_q, s12_p_q, s12_sq_q, s12_b_q;
  logic [31:0] s13_p_q, s13_a_q, s13_b_q;
  logic [31:0] p_d, fin_d;
  logic [PressW-1:0] pr_d;

  always_comb begin
    p_d   = div_side[0] ? (div_quo << 1) : div_quo;
    fin_d = s13_p_q + asr(s13_a_q + s13_b_q + p7, 4);
    if (s13_z_q)              pr_d = '0;
    else if (fin_d > 32'(PressMax)) pr_d = PressMax;
    else                      pr_d = fin_d[PressW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v11_q     <= 1'b0;
      v12_q     <= 1'b0;
      v13_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      v11_q     <= div_vld;
      v12_q     <= v11_q;
      v13_q     <= v12_q;
      out_vld_q <= v13_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s11_t_q  <= div_side[SideW-1:2];
      s11_z_q  <= div_side[1];
      s11_p_q  <= p_d;
      s12_t_q  <= s11_t_q;
      s12_z_q  <= s11_z_q;
      s12_p_q  <= s11_p_q;
      s12_sq_q <= mul32({3'b0, s11_p_q[31:3]}, {3'b0, s11_p_q[31:3]}) >> 13;
      s12_b_q  <= asr(mul32({2'b0, s11_p_q[31:2]}, p8), 13);
      s13_t_q  <= s12_t_q;
      s13_z_q  <= s12_z_q;
      s13_p_q  <= s12_p_q;
      s13_a_q  <= asr(mul32(p9, s12_sq_q), 12);
      s13_b_q  <= s12_b_q;
      temperature_centi_o <= s13_t_q;
      pressure_pa_o       <= pr_d;
    end
  end

  assign valid_o = out_vld_q;
endmodule

// ----- verif/tb_temp_press_compensation_unit.sv -----
// Testbench for temp_press_compensation_unit: directed and random sensor words checked
// against an in-bench integer compensation predictor, with random idling and back-pressure.
// Depends on tpc_pkg and the unit's RTL.
module tb_temp_press_compensation_unit;
  import tpc_pkg::*;

  localparam logic [RegIdxW-1:0] RegSpareA = 3'd6;
  localparam logic [RegIdxW-1:0] RegSpareB = 3'd7;
  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned TailCycles = 60;

  typedef struct packed {
    logic signed [TempW-1:0] temp;
    logic [PressW-1:0]       press;
  } reading_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [RegIdxW-1:0]      cfg_idx_i;
  logic [31:0]             cfg_wdata_i;
  logic                    valid_i;
  logic                    stall_o;
  logic [RawW-1:0]         raw_temperature_i;
  logic [RawW-1:0]         raw_pressure_i;
  logic                    valid_o;
  logic                    stall_i;
  logic signed [TempW-1:0] temperature_centi_o;
  logic [PressW-1:0]       pressure_pa_o;

  temp_press_compensation_unit uut (.*);

  logic [31:0] cal_words [NumRegs];
  reading_t    readings_due [$];
  int unsigned mismatches;
  int unsigned words_in;
  int unsigned words_out;
  int unsigned sat_hits;
  int unsigned zero_div_hits;
  bit          gaps_on;
  bit          stalls_on;
  int unsigned hold_req;
  int unsigned hold_left;
  int unsigned burst_left;
  int unsigned quiet;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [31:0] sra32(input logic [31:0] x, input int unsigned n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sext(input logic [15:0] h);
    return {{16{h[15]}}, h};
  endfunction

  function automatic reading_t compensate(input logic [RawW-1:0] rt, input logic [RawW-1:0] rp);
    logic [31:0] adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] a, b, d, fine, tc, p, q;
    reading_t r;
    adc_t = {12'd0, rt};
    adc_p = {12'd0, rp};
    t1 = {16'd0, cal_words[0][15:0]};  t2 = sext(cal_words[0][31:16]);
    t3 = sext(cal_words[1][15:0]);     p1 = {16'd0, cal_words[1][31:16]};
    p2 = sext(cal_words[2][15:0]);     p3 = sext(cal_words[2][31:16]);
    p4 = sext(cal_words[3][15:0]);     p5 = sext(cal_words[3][31:16]);
    p6 = sext(cal_words[4][15:0]);     p7 = sext(cal_words[4][31:16]);
    p8 = sext(cal_words[5][15:0]);     p9 = sext(cal_words[5][31:16]);
    a = sra32(((adc_t >> 3) - (t1 << 1)) * t2, 11);
    d = (adc_t >> 4) - t1;
    b = sra32(sra32(d * d, 12) * t3, 14);
    fine = a + b;
    tc = sra32(fine * 32'd5 + 32'd128, 8);
    if ($signed(tc) < -32768) r.temp = 16'sh8000;
    else if ($signed(tc) > 32767) r.temp = 16'sh7fff;
    else r.temp = tc[15:0];
    a = sra32(fine, 1) - 32'd64000;
    q = sra32(a, 2);
    b = sra32(q * q, 11) * p6;
    b = b + ((a * p5) << 1);
    b = sra32(b, 2) + (p4 << 16);
    a = sra32(sra32(p3 * sra32(q * q, 13), 3) + sra32(p2 * a, 1), 18);
    a = sra32((32'd32768 + a) * p1, 15);
    if (a == 32'd0) begin
      r.press = '0;
    end else begin
      p = ((32'd1048576 - adc_p) - sra32(b, 12)) * 32'd3125;
      if (p < 32'h8000_0000) p = (p << 1) / a;
      else p = (p / a) << 1;
      a = sra32(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
      b = sra32((p >> 2) * p8, 13);
      p = p + sra32(a + b + p7, 4);
      r.press = (p > 32'd262143) ? 18'h3ffff : p[17:0];
    end
    return r;
  endfunction

  // receiver: random stall bursts, or a long hold on request
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      stall_i <= 1'b1;
    end else if (!stalls_on) begin
      stall_i <= 1'b0;
    end else if (burst_left != 0) begin
      burst_left--;
      stall_i <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      burst_left = $urandom_range(0, 8);
      stall_i <= 1'b1;
    end else begin
      stall_i <= 1'b0;
    end
  end

  // result checker and watchdog, sampled mid-cycle
  always @(negedge clk_i) begin
    reading_t want;
    if (rst_ni && valid_o && !stall_i) begin
      words_out++;
      if (readings_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: temp %0d press %0d",
                   temperature_centi_o, pressure_pa_o);
      end else begin
        want = readings_due.pop_front();
        if (want.temp !== temperature_centi_o || want.press !== pressure_pa_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: temp exp %0d got %0d, press exp %0d got %0d",
                     want.temp, temperature_centi_o, want.press, pressure_pa_o);
        end
      end
    end
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) quiet = 0;
    else quiet++;
    if (quiet >= QuietLimit) begin
      $display("watchdog expired with %0d results outstanding", readings_due.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_word(input logic [RawW-1:0] rt, input logic [RawW-1:0] rp);
    reading_t r;
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    raw_temperature_i <= rt;
    raw_pressure_i <= rp;
    forever begin
      @(negedge clk_i);
      if (!stall_o) break;
    end
    @(posedge clk_i);
    r = compensate(rt, rp);
    if (r.temp == 16'sh7fff || r.temp == 16'sh8000 || r.press == 18'h3ffff) sat_hits++;
    if (r.press == '0) zero_div_hits++;
    readings_due.push_back(r);
    words_in++;
  endtask

  task automatic drain();
    valid_i <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic cal_write(input logic [RegIdxW-1:0] idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx < NumRegs) cal_words[idx] = val;
  endtask

  task automatic load_cal(input logic [31:0] w0, w1, w2, w3, w4, w5);
    cal_write(REG_T1_T2, w0);
    cal_write(REG_T3_P1, w1);
    cal_write(REG_P2_P3, w2);
    cal_write(REG_P4_P5, w3);
    cal_write(REG_P6_P7, w4);
    cal_write(REG_P8_P9, w5);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_typical_cal();
    load_cal({16'd26435, 16'd27504}, {16'd36477, 16'hfc18}, {16'd3024, 16'hd643},
             {16'd140, 16'd2855}, {16'd15500, 16'hfff9}, {16'd6000, 16'hc6f8});
  endtask

  task automatic send_edges();
    send_word('0, '0);
    send_word('1, '1);
    send_word('0, '1);
    send_word('1, '0);
    send_word(20'd519888, 20'd415148);
    send_word(20'h80000, 20'h7ffff);
  endtask

  task automatic test_reset_calibration();
    send_word(20'd519888, 20'd415148);
    send_edges();
    drain();
  endtask

  task automatic test_typical_calibration();
    load_typical_cal();
    send_edges();
    send_word(20'd440000, 20'd300000);
    send_word(20'd600000, 20'd100000);
    drain();
  endtask

  task automatic test_extreme_calibration();
    load_cal('1, '1, '1, '1, '1, '1);
    send_edges();
    drain();
    load_cal(32'h7fff_0000, 32'hffff_7fff, 32'h7fff_7fff,
             32'h7fff_7fff, 32'h7fff_7fff, 32'h7fff_7fff);
    send_edges();
    drain();
    load_cal(32'h8000_ffff, 32'h0001_8000, 32'h8000_8000,
             32'h8000_8000, 32'h8000_8000, 32'h8000_8000);
    send_edges();
    drain();
  endtask

  task automatic test_spare_index();
    load_typical_cal();
    cal_write(RegSpareA, '0);
    cal_write(RegSpareB, '1);
    cfg_we_i <= 1'b0;
    send_word(20'd519888, 20'd415148);
    send_word(20'd500000, 20'd350000);
    drain();
  endtask

  task automatic send_random(input int unsigned n);
    logic [RawW-1:0] rt, rp;
    repeat (n) begin
      rt = RawW'($urandom);
      rp = RawW'($urandom);
      if ($urandom_range(0, 9) == 0) rt = $urandom_range(0, 1) ? '1 : '0;
      if ($urandom_range(0, 9) == 0) rp = $urandom_range(0, 1) ? '1 : '0;
      send_word(rt, rp);
    end
  endtask

  task automatic test_random_calibration();
    logic [31:0] w [NumRegs];
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    repeat (8) begin
      for (int i = 0; i < NumRegs; i++) w[i] = $urandom;
      if ($urandom_range(0, 1) == 0) begin
        // nudge near realistic values so pressure rarely divides by zero
        w[0] = {16'd26435 ^ 16'($urandom_range(0, 255)), 16'd27504 + 16'($urandom_range(0, 3000))};
        w[1][31:16] = 16'd36477 + 16'($urandom_range(0, 4000));
      end
      load_cal(w[0], w[1], w[2], w[3], w[4], w[5]);
      send_random(37);
      drain();
    end
  endtask

  task automatic test_back_pressure();
    load_typical_cal();
    gaps_on = 1'b0;
    hold_req = 300;
    send_random(80);
    drain();
  endtask

  task automatic test_no_idling();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    send_random(40);
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    valid_i = 1'b0;
    raw_temperature_i = '0;
    raw_pressure_i = '0;
    stall_i = 1'b0;
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    hold_req = 0;
    hold_left = 0;
    burst_left = 0;
    quiet = 0;
    mismatches = 0;
    words_in = 0;
    words_out = 0;
    sat_hits = 0;
    zero_div_hits = 0;
    for (int i = 0; i < NumRegs; i++) cal_words[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_calibration();
    test_typical_calibration();
    test_extreme_calibration();
    test_spare_index();
    test_random_calibration();
    test_back_pressure();
    test_no_idling();

    $display("covered %0d words in, %0d results out, %0d saturated, %0d zero-divisor",
             words_in, words_out, sat_hits, zero_div_hits);
    $display("mismatches: %0d over reset, datasheet, extreme and random calibrations",
             mismatches);
    if (mismatches == 0 && readings_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
